// ===== sv/btlca_pkg.sv =====
// ----------------------------------------------------------------------------
// btlca_pkg
// Shared constants and codes for the binary tree link / LCA core.
// ----------------------------------------------------------------------------
`default_nettype none

package btlca_pkg;

  localparam int unsigned NODES_DEFAULT = 1024;
  localparam int unsigned NODE_W        = 10;
  localparam int unsigned STATUS_W      = 2;

  localparam logic OP_LINK  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_LINKED   = 2'd0,
    STATUS_REFUSED  = 2'd1,
    STATUS_ANSWERED = 2'd2
  } status_e;

  // walk phases of a query: bit 1 = unmark, bit 0 = second node
  localparam logic [1:0] PH_MARK_A   = 2'd0;
  localparam logic [1:0] PH_MARK_B   = 2'd1;
  localparam logic [1:0] PH_UNMARK_A = 2'd2;
  localparam logic [1:0] PH_UNMARK_B = 2'd3;

endpackage

`default_nettype wire

// ===== sv/btlca_ram.sv =====
// ----------------------------------------------------------------------------
// btlca_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module btlca_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/binary_tree_link_and_lca_core.sv =====
// ----------------------------------------------------------------------------
// binary_tree_link_and_lca_core
// Binary tree in a node memory (parent, left, right, mark) with link and
// lowest-common-ancestor transactions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries operation_i, node_a_i,
//   node_b_i. Output channel (out_valid_o / out_stall_i) returns status_o and
//   ancestor_o, exactly one result transaction per input transaction, in order.
//   After reset a clearing pass writes every node record, with in_stall_o high;
//   node 1 then hangs under node 0.
//   One transaction is processed at a time; all state lives in one node RAM
//   with one read and one write per cycle, so the sequencer sets the rate.
//   Link: ST_L_CHK, ST_L_A, ST_L_OLD (if A had a parent), ST_L_B, ST_L_PA. Query:
//   mark walks from A and B (one walk step per cycle), a descent from node 1
//   along matching marks, then unmark walks. Out-of-range nodes go straight
//   to ST_DONE, a link to a full target after ST_L_CHK. The next transaction
//   is accepted once the result register loads. Each walk stops at NODES steps.
//   The result register lets the next transaction be accepted while a result
//   waits; a finished result then holds in the core until the output drains.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_tree_link_and_lca_core #(
  parameter int unsigned NODES = btlca_pkg::NODES_DEFAULT
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             operation_i,
  input  wire logic [btlca_pkg::NODE_W-1:0]     node_a_i,
  input  wire logic [btlca_pkg::NODE_W-1:0]     node_b_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic      [btlca_pkg::STATUS_W-1:0]   status_o,
  output logic      [btlca_pkg::NODE_W-1:0]     ancestor_o
);

  localparam int unsigned IDW    = $clog2(NODES);
  localparam int unsigned STEP_W = IDW + 1;

  typedef struct packed {
    logic [IDW-1:0] parent;
    logic [IDW-1:0] left;
    logic [IDW-1:0] right;
    logic [1:0]     mark;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_CLEAR   = 4'd1;
  localparam logic [3:0] ST_L_CHK   = 4'd2;
  localparam logic [3:0] ST_L_A     = 4'd3;
  localparam logic [3:0] ST_L_OLD   = 4'd4;
  localparam logic [3:0] ST_L_B     = 4'd5;
  localparam logic [3:0] ST_L_PA    = 4'd6;
  localparam logic [3:0] ST_W_ISSUE = 4'd7;
  localparam logic [3:0] ST_W_STEP  = 4'd8;
  localparam logic [3:0] ST_D_CUR   = 4'd9;
  localparam logic [3:0] ST_D_LC    = 4'd10;
  localparam logic [3:0] ST_D_RC    = 4'd11;
  localparam logic [3:0] ST_DONE    = 4'd12;

  logic [3:0]         state_q, state_d;
  logic [IDW-1:0]     clr_q, clr_d;
  logic [IDW-1:0]     a_q, a_d, b_q, b_d;
  logic [IDW-1:0]     old_q, old_d;
  logic [IDW-1:0]     v_q, v_d;
  logic [IDW-1:0]     anc_q, anc_d;
  logic [IDW-1:0]     lc_q, lc_d;
  logic [IDW-1:0]     cur_rc_q, cur_rc_d;
  logic [1:0]         cur_mark_q, cur_mark_d;
  logic [1:0]         phase_q, phase_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [STEP_W-1:0]  step_inc;
  logic               step_more;
  btlca_pkg::status_e res_q, res_d;

  logic                              out_valid_q, out_valid_d;
  logic [btlca_pkg::STATUS_W-1:0]    out_status_q, out_status_d;
  logic [btlca_pkg::NODE_W-1:0]      out_anc_q, out_anc_d;
  logic                              out_load;

  logic             ram_we, ram_re;
  logic [IDW-1:0]   ram_waddr, ram_raddr;
  rec_t             ram_wdata;
  logic [REC_W-1:0] ram_rdata;
  logic             fwd_hit_q;
  rec_t             fwd_data_q;
  rec_t             rd_rec;
  rec_t             wr_rec;

  logic in_accept;
  logic a_in_range, b_in_range;

  btlca_ram #(
    .WIDTH (REC_W),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (REC_W'(ram_wdata)),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // read-during-write to the same entry returns the written record
  assign rd_rec = fwd_hit_q ? fwd_data_q : rec_t'(ram_rdata);

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign a_in_range = (32'(node_a_i) < 32'(NODES));
  assign b_in_range = (32'(node_b_i) < 32'(NODES));

  assign step_inc  = step_q + STEP_W'(1);
  assign step_more = (step_inc < STEP_W'(NODES));

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    a_d        = a_q;
    b_d        = b_q;
    old_d      = old_q;
    v_d        = v_q;
    anc_d      = anc_q;
    lc_d       = lc_q;
    cur_rc_d   = cur_rc_q;
    cur_mark_d = cur_mark_q;
    phase_d    = phase_q;
    step_d     = step_q;
    res_d      = res_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    wr_rec     = rd_rec;
    out_load   = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_q;
        wr_rec      = '0;
        wr_rec.left = (clr_q == '0) ? IDW'(1) : '0;
        clr_d       = clr_q + IDW'(1);
        if (clr_q == IDW'(NODES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          a_d = IDW'(node_a_i);
          b_d = IDW'(node_b_i);
          if (!(a_in_range && b_in_range)) begin
            anc_d   = '0;
            res_d   = (operation_i == btlca_pkg::OP_LINK) ? btlca_pkg::STATUS_REFUSED
                                                          : btlca_pkg::STATUS_ANSWERED;
            state_d = ST_DONE;
          end else if (operation_i == btlca_pkg::OP_LINK) begin
            ram_re    = 1'b1;
            ram_raddr = IDW'(node_b_i);
            state_d   = ST_L_CHK;
          end else begin
            phase_d = btlca_pkg::PH_MARK_A;
            state_d = ST_W_ISSUE;
          end
        end
      end
      ST_L_CHK: begin
        if (rd_rec.left != '0 && rd_rec.right != '0) begin
          res_d   = btlca_pkg::STATUS_REFUSED;
          state_d = ST_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = a_q;
          state_d   = ST_L_A;
        end
      end
      ST_L_A: begin
        old_d  = rd_rec.parent;
        ram_re = 1'b1;
        if (rd_rec.parent != '0) begin
          ram_raddr = rd_rec.parent;
          state_d   = ST_L_OLD;
        end else begin
          ram_raddr = b_q;
          state_d   = ST_L_B;
        end
      end
      ST_L_OLD: begin
        if (rd_rec.left == a_q) begin
          wr_rec.left = '0;
        end
        if (rd_rec.right == a_q) begin
          wr_rec.right = '0;
        end
        ram_we    = 1'b1;
        ram_waddr = old_q;
        ram_re    = 1'b1;
        ram_raddr = b_q;
        state_d   = ST_L_B;
      end
      ST_L_B: begin
        if (rd_rec.left == '0) begin
          wr_rec.left = a_q;
        end else begin
          wr_rec.right = a_q;
        end
        ram_we    = 1'b1;
        ram_waddr = b_q;
        ram_re    = 1'b1;
        ram_raddr = a_q;
        state_d   = ST_L_PA;
      end
      ST_L_PA: begin
        wr_rec.parent = b_q;
        ram_we        = 1'b1;
        ram_waddr     = a_q;
        res_d         = btlca_pkg::STATUS_LINKED;
        state_d       = ST_DONE;
      end
      ST_W_ISSUE: begin
        v_d    = phase_q[0] ? b_q : a_q;
        step_d = '0;
        if (v_d != '0) begin
          ram_re    = 1'b1;
          ram_raddr = v_d;
          state_d   = ST_W_STEP;
        end else begin
          state_d = ST_W_STEP;
        end
      end
      ST_W_STEP: begin
        if (v_q != '0) begin
          wr_rec.mark = rd_rec.mark + (phase_q[1] ? 2'd3 : 2'd1);
          ram_we      = 1'b1;
          ram_waddr   = v_q;
          step_d      = step_inc;
        end
        if (v_q != '0 && rd_rec.parent != '0 && step_more) begin
          v_d       = rd_rec.parent;
          ram_re    = 1'b1;
          ram_raddr = rd_rec.parent;
        end else begin
          unique case (phase_q)
            btlca_pkg::PH_MARK_A: begin
              phase_d = btlca_pkg::PH_MARK_B;
              state_d = ST_W_ISSUE;
            end
            btlca_pkg::PH_MARK_B: begin
              anc_d     = IDW'(1);
              step_d    = '0;
              ram_re    = 1'b1;
              ram_raddr = IDW'(1);
              state_d   = ST_D_CUR;
            end
            btlca_pkg::PH_UNMARK_A: begin
              phase_d = btlca_pkg::PH_UNMARK_B;
              state_d = ST_W_ISSUE;
            end
            default: begin
              res_d   = btlca_pkg::STATUS_ANSWERED;
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_D_CUR: begin
        cur_mark_d = rd_rec.mark;
        cur_rc_d   = rd_rec.right;
        lc_d       = rd_rec.left;
        ram_re     = 1'b1;
        ram_raddr  = rd_rec.left;
        state_d    = ST_D_LC;
      end
      ST_D_LC, ST_D_RC: begin
        if (rd_rec.mark == cur_mark_q) begin
          anc_d      = (state_q == ST_D_LC) ? lc_q : cur_rc_q;
          cur_mark_d = rd_rec.mark;
          cur_rc_d   = rd_rec.right;
          lc_d       = rd_rec.left;
          step_d     = step_inc;
          if (step_more) begin
            ram_re    = 1'b1;
            ram_raddr = rd_rec.left;
            state_d   = ST_D_LC;
          end else begin
            phase_d = btlca_pkg::PH_UNMARK_A;
            state_d = ST_W_ISSUE;
          end
        end else if (state_q == ST_D_LC) begin
          ram_re    = 1'b1;
          ram_raddr = cur_rc_q;
          state_d   = ST_D_RC;
        end else begin
          phase_d = btlca_pkg::PH_UNMARK_A;
          state_d = ST_W_ISSUE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign ram_wdata = wr_rec;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_anc_d    = out_anc_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_status_d = res_q;
      out_anc_d    = (res_q == btlca_pkg::STATUS_ANSWERED) ?
                     btlca_pkg::NODE_W'(anc_q) : '0;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      phase_q     <= btlca_pkg::PH_MARK_A;
      step_q      <= '0;
      res_q       <= btlca_pkg::STATUS_LINKED;
      out_valid_q <= 1'b0;
      fwd_hit_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      phase_q     <= phase_d;
      step_q      <= step_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      fwd_hit_q   <= ram_we && ram_re && (ram_waddr == ram_raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    a_q          <= a_d;
    b_q          <= b_d;
    old_q        <= old_d;
    v_q          <= v_d;
    anc_q        <= anc_d;
    lc_q         <= lc_d;
    cur_rc_q     <= cur_rc_d;
    cur_mark_q   <= cur_mark_d;
    out_status_q <= out_status_d;
    out_anc_q    <= out_anc_d;
    fwd_data_q   <= ram_wdata;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign ancestor_o  = out_anc_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q != ST_IDLE)
    else $error("accepted transaction did not start");

  // the counter can reach NODES when a walk or the descent hits the cap
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= STEP_W'(NODES))
    else $error("walk step counter passed node count");

  a_clear_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(state_q == ST_CLEAR) |-> $past(clr_q) == IDW'(NODES - 1))
    else $error("clearing pass ended early");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("result issued outside done state");

endmodule

`default_nettype wire
